### hdl/smbd_pkg.sv
// Shared types, codes and helpers for the sticky modifier button decoder.
// No dependencies; imported by smbd_core and the top level.
package smbd_pkg;

  localparam logic [7:0] WINDOW_RESET = 8'd3;
  localparam int NUM_MODS = 4;

  typedef enum logic [3:0] {
    OP_BRIGHT_DOWN = 4'd0,
    OP_BRIGHT_UP   = 4'd1,
    OP_SCROLL_DOWN = 4'd2,
    OP_SCROLL_UP   = 4'd3,
    OP_DIRECTION   = 4'd4,
    OP_FN          = 4'd5,
    OP_MENU        = 4'd6,
    OP_TABLET      = 4'd7,
    OP_OTHER       = 4'd8
  } opcode_t;

  typedef enum logic [4:0] {
    ACT_NONE          = 5'd0,
    ACT_BRIGHT_DOWN   = 5'd1,
    ACT_BRIGHT_UP     = 5'd2,
    ACT_WHEEL_DOWN    = 5'd3,
    ACT_WHEEL_UP      = 5'd4,
    ACT_PAGE_DOWN     = 5'd5,
    ACT_PAGE_UP       = 5'd6,
    ACT_ROTATE_TOGGLE = 5'd7,
    ACT_TABLET_ROTATE = 5'd8,
    ACT_LAUNCH        = 5'd9,
    ACT_FN_PROMPT     = 5'd10,
    ACT_ALT_PROMPT    = 5'd11,
    ACT_ALTFN_PROMPT  = 5'd12,
    ACT_CFG_PROMPT    = 5'd13,
    ACT_SCROLL_TOGGLE = 5'd14,
    ACT_LOCK_TOGGLE   = 5'd15,
    ACT_UNSUPPORTED   = 5'd16
  } action_t;

  typedef enum logic [1:0] {
    MOD_FN   = 2'd0,
    MOD_ALT  = 2'd1,
    MOD_BOTH = 2'd2,
    MOD_CFG  = 2'd3
  } mod_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  launch_index;
    logic        clear_display;
    logic        scroll_page_mode;
    logic        rotation_locked;
  } result_t;

  // Launch keys are numbered in rows of five per modifier, one per button.
  function automatic logic [3:0] launch_key(input mod_t m, input logic [2:0] k);
    logic [3:0] base;
    case (m)
      MOD_ALT:  base = 4'd5;
      MOD_BOTH: base = 4'd10;
      default:  base = 4'd0;
    endcase
    return base + {1'b0, k};
  endfunction

endpackage

### hdl/smbd_core.sv
// Modifier state, mode flags, window register and the per-event decision.
// Depends on smbd_pkg.
module smbd_core
  import smbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        step,
  input  logic [3:0]  op_raw,
  input  logic [31:0] now,
  output result_t     result
);

  logic [NUM_MODS-1:0] arm_bit;
  logic [NUM_MODS-1:0] arm_bit_next;
  logic [31:0]         stamp [NUM_MODS];
  logic [NUM_MODS-1:0] stamp_load;
  logic                page_mode;
  logic                page_mode_next;
  logic                lock_flag;
  logic                lock_flag_next;
  logic [7:0]          window;
  logic [NUM_MODS-1:0] live;
  logic [2:0]          k;
  opcode_t             op;

  assign op = opcode_t'(op_raw);
  assign k  = 3'(op_raw - 4'd2);

  always_comb begin
    for (int m = 0; m < NUM_MODS; m++) begin
      live[m] = arm_bit[m] && ((now - stamp[m]) < {24'd0, window});
    end
  end

  always_comb begin
    arm_bit_next          = arm_bit;
    stamp_load            = '0;
    page_mode_next        = page_mode;
    lock_flag_next        = lock_flag;
    result.action         = ACT_NONE;
    result.launch_index   = 4'd0;
    result.clear_display  = 1'b0;
    case (op)
      OP_BRIGHT_DOWN: begin
        result.action = ACT_BRIGHT_DOWN;
        arm_bit_next  = '0;
      end
      OP_BRIGHT_UP: begin
        result.action = ACT_BRIGHT_UP;
        arm_bit_next  = '0;
      end
      OP_TABLET: begin
        result.action = lock_flag ? ACT_NONE : ACT_TABLET_ROTATE;
        arm_bit_next  = '0;
      end
      OP_SCROLL_DOWN, OP_SCROLL_UP, OP_DIRECTION, OP_FN, OP_MENU: begin
        if (live[MOD_FN]) begin
          arm_bit_next[MOD_FN] = 1'b0;
          if (op == OP_MENU) begin
            arm_bit_next          = '0;
            arm_bit_next[MOD_CFG] = 1'b1;
            stamp_load[MOD_CFG]   = 1'b1;
            result.action         = ACT_CFG_PROMPT;
          end else begin
            result.action       = ACT_LAUNCH;
            result.launch_index = launch_key(MOD_FN, k);
          end
        end else if (live[MOD_ALT]) begin
          arm_bit_next[MOD_ALT] = 1'b0;
          if (op == OP_FN) begin
            arm_bit_next[MOD_BOTH] = 1'b1;
            stamp_load[MOD_BOTH]   = 1'b1;
            result.action          = ACT_ALTFN_PROMPT;
          end else begin
            result.action       = ACT_LAUNCH;
            result.launch_index = launch_key(MOD_ALT, k);
          end
        end else if (live[MOD_BOTH]) begin
          arm_bit_next[MOD_BOTH] = 1'b0;
          result.action          = ACT_LAUNCH;
          result.launch_index    = launch_key(MOD_BOTH, k);
        end else if (live[MOD_CFG]) begin
          arm_bit_next[MOD_CFG] = 1'b0;
          result.clear_display  = 1'b1;
          if (op == OP_SCROLL_DOWN || op == OP_SCROLL_UP) begin
            page_mode_next = ~page_mode;
            result.action  = ACT_SCROLL_TOGGLE;
          end else if (op == OP_DIRECTION) begin
            lock_flag_next = ~lock_flag;
            result.action  = ACT_LOCK_TOGGLE;
          end else begin
            result.action = ACT_NONE;
          end
        end else begin
          case (op)
            OP_SCROLL_DOWN: result.action = page_mode ? ACT_PAGE_DOWN : ACT_WHEEL_DOWN;
            OP_SCROLL_UP:   result.action = page_mode ? ACT_PAGE_UP : ACT_WHEEL_UP;
            OP_DIRECTION:   result.action = ACT_ROTATE_TOGGLE;
            OP_FN: begin
              arm_bit_next[MOD_FN] = 1'b1;
              stamp_load[MOD_FN]   = 1'b1;
              result.action        = ACT_FN_PROMPT;
            end
            default: begin
              arm_bit_next[MOD_ALT] = 1'b1;
              stamp_load[MOD_ALT]   = 1'b1;
              result.action         = ACT_ALT_PROMPT;
            end
          endcase
        end
      end
      default: begin
        result.action = ACT_UNSUPPORTED;
      end
    endcase
    result.scroll_page_mode = page_mode_next;
    result.rotation_locked  = lock_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_bit   <= '0;
      page_mode <= 1'b0;
      lock_flag <= 1'b0;
      window    <= WINDOW_RESET;
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (step) begin
        arm_bit   <= arm_bit_next;
        page_mode <= page_mode_next;
        lock_flag <= lock_flag_next;
      end
    end
  end

  // Stamps only matter while the matching armed bit is set.
  always_ff @(posedge clk) begin
    for (int m = 0; m < NUM_MODS; m++) begin
      if (step && stamp_load[m]) begin
        stamp[m] <= now;
      end
    end
  end

endmodule

### hdl/sticky_modifier_button_decoder.sv
// Sticky modifier button decoder, top level: input register, decision core, result register.
// An accepted beat waits in the input register until the result register is free or taken.
// Throughput: one beat per cycle while results are taken; input stalls only when both
// registers are full and the result is not taken; the combinational core sets this rate.
// Reset (rst, synchronous): all modifiers disarmed, wheel mode, unlocked, window 3 seconds.
// Depends on smbd_pkg and smbd_core.
module sticky_modifier_button_decoder
  import smbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  action,
  output logic [3:0]  launch_index,
  output logic        clear_display,
  output logic        scroll_page_mode,
  output logic        rotation_locked
);

  logic        hold_valid;
  logic [3:0]  hold_op;
  logic [31:0] hold_now;
  logic        res_valid;
  result_t     res;
  result_t     core_res;
  logic        advance;
  logic        step;

  assign advance  = !res_valid || out_ready;
  assign in_ready = !hold_valid || advance;
  assign step     = hold_valid && advance;

  smbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .op_raw    (hold_op),
    .now       (hold_now),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (advance) begin
        res_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_op  <= opcode;
      hold_now <= now_seconds;
    end
    if (step) begin
      res <= core_res;
    end
  end

  assign out_valid        = res_valid;
  assign action           = res.action;
  assign launch_index     = res.launch_index;
  assign clear_display    = res.clear_display;
  assign scroll_page_mode = res.scroll_page_mode;
  assign rotation_locked  = res.rotation_locked;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for sticky_modifier_button_decoder: a directed table of events, then random event
// streams over several windows; each beat checked against a local decoder model or fixed result.
// Depends on smbd_pkg and the decoder RTL.
module testbench;
  import smbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 48;
  localparam int REPORT_CAP = 200;
  localparam logic [3:0] OP_TOP = 4'hF;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] t;
    bit          fixed;
    result_t     res;
  } event_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  opcode = 4'd0;
  logic [31:0] now_seconds = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  action;
  logic [3:0]  launch_index;
  logic        clear_display;
  logic        scroll_page_mode;
  logic        rotation_locked;

  logic [31:0] mod_stamp [NUM_MODS];
  logic        mod_armed [NUM_MODS];
  logic        page_q;
  logic        lock_q;
  logic [7:0]  win_q;
  logic [31:0] clock_s = 32'd0;

  result_t     pending_results [$];
  event_row_t  directed_rows [$];
  logic [3:0]  op_plan [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int err_count = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  sticky_modifier_button_decoder u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .now_seconds      (now_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .launch_index     (launch_index),
    .clear_display    (clear_display),
    .scroll_page_mode (scroll_page_mode),
    .rotation_locked  (rotation_locked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit mod_live(mod_t m, logic [31:0] t);
    logic [31:0] age;
    age = t - mod_stamp[m];
    return mod_armed[m] && (age < {24'd0, win_q});
  endfunction

  function automatic void mod_clear(mod_t m);
    mod_armed[m] = 1'b0;
    mod_stamp[m] = 32'd0;
  endfunction

  function automatic void mod_set(mod_t m, logic [31:0] t);
    mod_armed[m] = 1'b1;
    mod_stamp[m] = t;
  endfunction

  function automatic void mods_clear_all();
    for (int i = 0; i < NUM_MODS; i++) mod_clear(mod_t'(i));
  endfunction

  function automatic result_t decode_event(logic [3:0] op, logic [31:0] t);
    result_t r;
    logic [2:0] key;
    r = '0;
    key = 3'(op - OP_SCROLL_DOWN);
    if (op == OP_BRIGHT_DOWN || op == OP_BRIGHT_UP) begin
      r.action = (op == OP_BRIGHT_DOWN) ? ACT_BRIGHT_DOWN : ACT_BRIGHT_UP;
      mods_clear_all();
    end else if (op == OP_TABLET) begin
      r.action = lock_q ? ACT_NONE : ACT_TABLET_ROTATE;
      mods_clear_all();
    end else if (op >= OP_SCROLL_DOWN && op <= OP_MENU) begin
      if (mod_live(MOD_FN, t)) begin
        mod_clear(MOD_FN);
        if (op == OP_MENU) begin
          mods_clear_all();
          mod_set(MOD_CFG, t);
          r.action = ACT_CFG_PROMPT;
        end else begin
          r.action = ACT_LAUNCH;
          r.launch_index = {1'b0, key};
        end
      end else if (mod_live(MOD_ALT, t)) begin
        mod_clear(MOD_ALT);
        if (op == OP_FN) begin
          mod_set(MOD_BOTH, t);
          r.action = ACT_ALTFN_PROMPT;
        end else begin
          r.action = ACT_LAUNCH;
          r.launch_index = 4'd5 + {1'b0, key};
        end
      end else if (mod_live(MOD_BOTH, t)) begin
        mod_clear(MOD_BOTH);
        r.action = ACT_LAUNCH;
        r.launch_index = 4'd10 + {1'b0, key};
      end else if (mod_live(MOD_CFG, t)) begin
        mod_clear(MOD_CFG);
        r.clear_display = 1'b1;
        if (op <= OP_SCROLL_UP) begin
          page_q = ~page_q;
          r.action = ACT_SCROLL_TOGGLE;
        end else if (op == OP_DIRECTION) begin
          lock_q = ~lock_q;
          r.action = ACT_LOCK_TOGGLE;
        end else begin
          r.action = ACT_NONE;
        end
      end else begin
        case (op)
          OP_SCROLL_DOWN: r.action = page_q ? ACT_PAGE_DOWN : ACT_WHEEL_DOWN;
          OP_SCROLL_UP:   r.action = page_q ? ACT_PAGE_UP : ACT_WHEEL_UP;
          OP_DIRECTION:   r.action = ACT_ROTATE_TOGGLE;
          OP_FN: begin
            mod_set(MOD_FN, t);
            r.action = ACT_FN_PROMPT;
          end
          default: begin
            mod_set(MOD_ALT, t);
            r.action = ACT_ALT_PROMPT;
          end
        endcase
      end
    end else begin
      r.action = ACT_UNSUPPORTED;
    end
    r.scroll_page_mode = page_q;
    r.rotation_locked = lock_q;
    return r;
  endfunction

  function automatic void add_row(logic [3:0] op, logic [31:0] t);
    event_row_t row;
    row.op = op;
    row.t = t;
    row.fixed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_fixed(logic [3:0] op, logic [31:0] t, action_t a);
    event_row_t row;
    row.op = op;
    row.t = t;
    row.fixed = 1'b1;
    row.res = '0;
    row.res.action = a;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [31:0] next_stamp();
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    span = (win_q > 8'd12) ? 3 : int'(win_q) + 1;
    if (r < 70) clock_s = clock_s + $urandom_range(0, span);
    else if (r < 80) clock_s = clock_s + win_q - 1 + $urandom_range(0, 2);
    else if (r < 88) clock_s = clock_s - $urandom_range(1, 4);
    else if (r < 95) clock_s = $urandom;
    else clock_s = 32'hFFFF_FFFF - $urandom_range(0, 3);
    return clock_s;
  endfunction

  function automatic void refill_ops();
    logic [3:0] key;
    key = 4'($urandom_range(int'(OP_SCROLL_DOWN), int'(OP_MENU)));
    case ($urandom_range(0, 9))
      0, 1: begin
        op_plan.push_back(OP_FN);
        op_plan.push_back(key);
      end
      2, 3: begin
        op_plan.push_back(OP_MENU);
        op_plan.push_back(key);
      end
      4: begin
        op_plan.push_back(OP_MENU);
        op_plan.push_back(OP_FN);
        op_plan.push_back(key);
      end
      5, 6: begin
        op_plan.push_back(OP_FN);
        op_plan.push_back(OP_MENU);
        op_plan.push_back(key);
      end
      7: op_plan.push_back(4'($urandom_range(int'(OP_BRIGHT_DOWN), int'(OP_OTHER))));
      8: op_plan.push_back(4'($urandom_range(0, int'(OP_TOP))));
      default: op_plan.push_back(4'($urandom_range(int'(OP_SCROLL_DOWN), int'(OP_DIRECTION))));
    endcase
  endfunction

  task automatic report(string msg);
    err_count++;
    if (err_count <= REPORT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report($sformatf("beat %0d arrived with nothing expected", results_seen));
      return;
    end
    want = pending_results.pop_front();
    if (action !== want.action)
      report($sformatf("beat %0d action %0d, expected %0d", results_seen, action, want.action));
    if (launch_index !== want.launch_index)
      report($sformatf("beat %0d launch_index %0d, expected %0d", results_seen, launch_index,
                       want.launch_index));
    if (clear_display !== want.clear_display)
      report($sformatf("beat %0d clear_display %b, expected %b", results_seen, clear_display,
                       want.clear_display));
    if (scroll_page_mode !== want.scroll_page_mode)
      report($sformatf("beat %0d scroll_page_mode %b, expected %b", results_seen,
                       scroll_page_mode, want.scroll_page_mode));
    if (rotation_locked !== want.rotation_locked)
      report($sformatf("beat %0d rotation_locked %b, expected %b", results_seen,
                       rotation_locked, want.rotation_locked));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken, valid still high.
  task automatic send_beat(logic [3:0] op, logic [31:0] t, bit fixed, result_t fixed_res);
    result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    now_seconds = t;
    do @(posedge clk); while (!in_ready);
    want = decode_event(op, t);
    pending_results.push_back(fixed ? fixed_res : want);
    @(negedge clk);
  endtask

  task automatic set_window(logic [7:0] w);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we = 1'b0;
    win_q = w;
  endtask

  task automatic run_random(int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      if (op_plan.size() == 0) refill_ops();
      op = op_plan.pop_front();
      send_beat(op, next_stamp(), 1'b0, '0);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    mods_clear_all();
    page_q = 1'b0;
    lock_q = 1'b0;
    win_q = WINDOW_RESET;

    add_fixed(OP_BRIGHT_DOWN, 32'd0, ACT_BRIGHT_DOWN);
    add_fixed(OP_BRIGHT_UP, 32'hFFFF_FFFF, ACT_BRIGHT_UP);
    add_fixed(OP_TOP, 32'd0, ACT_UNSUPPORTED);
    add_fixed(OP_TABLET, 32'hAAAA_AAAA, ACT_TABLET_ROTATE);
    add_fixed(OP_SCROLL_DOWN, 32'h5555_5555, ACT_WHEEL_DOWN);
    add_fixed(OP_DIRECTION, 32'd1, ACT_ROTATE_TOGGLE);
    add_row(OP_FN, 32'd100);
    add_row(OP_SCROLL_DOWN, 32'd102);
    add_row(OP_MENU, 32'd200);
    add_row(OP_FN, 32'd201);
    add_row(OP_MENU, 32'd202);
    add_row(OP_FN, 32'd300);
    add_row(OP_MENU, 32'd301);
    add_row(OP_SCROLL_UP, 32'd303);
    add_row(OP_FN, 32'd400);
    add_row(OP_MENU, 32'd400);
    add_row(OP_DIRECTION, 32'd402);
    add_row(OP_TABLET, 32'd402);
    add_row(OP_FN, 32'd500);
    add_row(OP_MENU, 32'd500);
    add_row(OP_FN, 32'd501);
    add_row(OP_FN, 32'd600);
    add_row(OP_SCROLL_UP, 32'd603);
    add_row(OP_FN, 32'd700);
    add_row(OP_DIRECTION, 32'd699);
    add_row(OP_FN, 32'hFFFF_FFFF);
    add_row(OP_DIRECTION, 32'd1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 77;
    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].t, directed_rows[i].fixed,
                directed_rows[i].res);

    set_window(8'd255);
    run_random(300);

    send_idle_pct = 77;
    recv_idle_pct = 31;
    set_window(8'd1);
    run_random(250);
    set_window(8'd0);
    run_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(8'($urandom_range(2, 12)));
    hold_req = 1'b1;
    run_random(300);
    set_window(WINDOW_RESET);
    run_random(300);

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/smbd_pkg.sv
hdl/smbd_core.sv
hdl/sticky_modifier_button_decoder.sv
tb/testbench.sv
